[rtl/sqt_pkg.sv]
// shared types and character codes for the shell quote tokenizer
package sqt_pkg;

    localparam int unsigned ChW = 8;

    typedef enum logic [1:0] {
        MODE_GEN = 2'd0,
        MODE_SQ  = 2'd1,
        MODE_DQ  = 2'd2
    } lex_mode_t;

    localparam logic [ChW-1:0] CH_NUL    = 8'h00;
    localparam logic [ChW-1:0] CH_TAB    = 8'h09;
    localparam logic [ChW-1:0] CH_SPACE  = 8'h20;
    localparam logic [ChW-1:0] CH_DQUOTE = 8'h22;
    localparam logic [ChW-1:0] CH_AMP    = 8'h26;
    localparam logic [ChW-1:0] CH_SQUOTE = 8'h27;
    localparam logic [ChW-1:0] CH_SEMI   = 8'h3B;
    localparam logic [ChW-1:0] CH_LT     = 8'h3C;
    localparam logic [ChW-1:0] CH_GT     = 8'h3E;
    localparam logic [ChW-1:0] CH_BSLASH = 8'h5C;
    localparam logic [ChW-1:0] CH_PIPE   = 8'h7C;

    typedef struct packed {
        lex_mode_t mode;
        logic      esc_pending;
        logic      word_open;
    } lex_state_t;

    typedef struct packed {
        logic [ChW-1:0] out_byte;
        logic           has_byte;
        logic           token_kind;
        logic           token_end;
        lex_mode_t      quote_mode;
        logic           last;
    } result_t;

endpackage

[rtl/sqt_step.sv]
// combinational lexer step: one byte and the current state give up to two results
module sqt_step (
    input  logic [sqt_pkg::ChW-1:0] ch,
    input  sqt_pkg::lex_state_t     st,
    output sqt_pkg::lex_state_t     st_next,
    output sqt_pkg::result_t        res0,
    output sqt_pkg::result_t        res1,
    output logic [1:0]              res_cnt
);

    sqt_pkg::result_t   r0;
    sqt_pkg::result_t   r1;
    sqt_pkg::result_t   word_res;
    sqt_pkg::result_t   close_res;
    sqt_pkg::result_t   op_res;
    sqt_pkg::lex_state_t nxt;
    logic [1:0]          cnt;
    logic                in_quote;

    always_comb begin
        word_res   = '{out_byte: ch, has_byte: 1'b1, token_kind: 1'b0, token_end: 1'b0,
                       quote_mode: sqt_pkg::MODE_GEN, last: 1'b0};
        close_res  = '{out_byte: '0, has_byte: 1'b0, token_kind: 1'b0, token_end: 1'b1,
                       quote_mode: sqt_pkg::MODE_GEN, last: 1'b0};
        op_res     = '{out_byte: ch, has_byte: 1'b1, token_kind: 1'b1, token_end: 1'b1,
                       quote_mode: sqt_pkg::MODE_GEN, last: 1'b0};
        in_quote   = (st.mode == sqt_pkg::MODE_SQ) || (st.mode == sqt_pkg::MODE_DQ);
        nxt        = st;
        cnt        = 2'd0;
        r0         = close_res;
        r1         = close_res;

        if (ch == sqt_pkg::CH_NUL) begin
            // end of line closes any open word and drops quote and escape
            if (st.word_open) begin
                cnt = 2'd1;
            end
            nxt = '{mode: sqt_pkg::MODE_GEN, esc_pending: 1'b0, word_open: 1'b0};
        end else if (in_quote) begin
            r0            = word_res;
            cnt           = 2'd1;
            nxt.word_open = 1'b1;
            if ((st.mode == sqt_pkg::MODE_SQ && ch == sqt_pkg::CH_SQUOTE) ||
                (st.mode == sqt_pkg::MODE_DQ && ch == sqt_pkg::CH_DQUOTE)) begin
                nxt.mode = sqt_pkg::MODE_GEN;
            end
        end else begin
            nxt.mode = sqt_pkg::MODE_GEN;
            if (st.esc_pending) begin
                nxt.esc_pending = 1'b0;
                r0              = word_res;
                cnt             = 2'd1;
                nxt.word_open   = 1'b1;
            end else begin
                unique case (ch) inside
                    sqt_pkg::CH_BSLASH: begin
                        nxt.esc_pending = 1'b1;
                    end
                    sqt_pkg::CH_SQUOTE, sqt_pkg::CH_DQUOTE: begin
                        r0            = word_res;
                        cnt           = 2'd1;
                        nxt.word_open = 1'b1;
                        nxt.mode      = (ch == sqt_pkg::CH_SQUOTE) ? sqt_pkg::MODE_SQ
                                                                   : sqt_pkg::MODE_DQ;
                    end
                    sqt_pkg::CH_SPACE, sqt_pkg::CH_TAB: begin
                        if (st.word_open) begin
                            cnt = 2'd1;
                        end
                        nxt.word_open = 1'b0;
                    end
                    sqt_pkg::CH_SEMI, sqt_pkg::CH_GT, sqt_pkg::CH_LT,
                    sqt_pkg::CH_AMP, sqt_pkg::CH_PIPE: begin
                        if (st.word_open) begin
                            r1  = op_res;
                            cnt = 2'd2;
                        end else begin
                            r0  = op_res;
                            cnt = 2'd1;
                        end
                        nxt.word_open = 1'b0;
                    end
                    default: begin
                        r0            = word_res;
                        cnt           = 2'd1;
                        nxt.word_open = 1'b1;
                    end
                endcase
            end
        end

        r0.quote_mode = nxt.mode;
        r1.quote_mode = nxt.mode;
        r0.last       = (cnt == 2'd1);
        r1.last       = 1'b1;
    end

    assign st_next = nxt;
    assign res0    = r0;
    assign res1    = r1;
    assign res_cnt = cnt;

endmodule

[rtl/shell_quote_tokenizer.sv]
// top level of the shell quote tokenizer: input stage, lexer state, result buffer
// the first result of a byte passes the input stage register, then the result register, before it shows on m_
// throughput: one byte per cycle when each byte gives at most one result and m_tready stays high
// a byte that gives two results (word close plus operator) holds the input until its second result leaves the hold slot
// rate is set by the single result register draining one result per cycle while m_tready is high
// reset: synchronous active-low aresetn clears lexer state and all valid flags
module shell_quote_tokenizer (
    input  logic                    aclk,
    input  logic                    aresetn,
    // input byte stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [sqt_pkg::ChW-1:0] s_tdata,   // [7:0] ch
    // token result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [sqt_pkg::ChW-1:0] m_tdata,   // [7:0] out_byte
    output logic [4:0]              m_tuser,   // [0] has_byte, [1] token_kind,
                                               // [2] token_end, [4:3] quote_mode
    output logic                    m_tlast    // final result of one input byte
);

    // input stage register
    logic                    stage_valid_reg;
    logic                    stage_valid_next;
    logic [sqt_pkg::ChW-1:0] stage_ch_reg;

    // lexer state
    sqt_pkg::lex_state_t st_reg;
    sqt_pkg::lex_state_t st_new;

    // result register plus a hold slot for the second result of a byte
    sqt_pkg::result_t out_reg;
    sqt_pkg::result_t out_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    sqt_pkg::result_t hold_reg;
    sqt_pkg::result_t hold_next;
    logic             hold_valid_reg;
    logic             hold_valid_next;

    // step results
    sqt_pkg::result_t res0;
    sqt_pkg::result_t res1;
    logic [1:0]       res_cnt;

    logic out_free;
    logic stage_fire;

    sqt_step u_step (
        .ch      (stage_ch_reg),
        .st      (st_reg),
        .st_next (st_new),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    // result register can take a new value when empty or being drained
    assign out_free   = !out_valid_reg || m_tready;
    // the staged byte is processed only when both of its results have room
    assign stage_fire = stage_valid_reg && out_free && !hold_valid_reg;
    assign s_tready   = !stage_valid_reg || stage_fire;

    always_comb begin
        stage_valid_next = stage_valid_reg;
        if (s_tvalid && s_tready) begin
            stage_valid_next = 1'b1;
        end else if (stage_fire) begin
            stage_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        if (hold_valid_reg) begin
            // second result of the previous byte moves up
            if (out_free) begin
                out_next        = hold_reg;
                out_valid_next  = 1'b1;
                hold_valid_next = 1'b0;
            end
        end else if (stage_fire) begin
            case (res_cnt)
                2'd1: begin
                    out_next       = res0;
                    out_valid_next = 1'b1;
                end
                2'd2: begin
                    out_next        = res0;
                    out_valid_next  = 1'b1;
                    hold_next       = res1;
                    hold_valid_next = 1'b1;
                end
                default: begin
                    // byte with no result, e.g. a blank outside a word
                    out_valid_next = 1'b0;
                end
            endcase
        end else if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            hold_valid_reg  <= 1'b0;
            st_reg          <= '{mode: sqt_pkg::MODE_GEN, esc_pending: 1'b0,
                                 word_open: 1'b0};
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            hold_valid_reg  <= hold_valid_next;
            if (stage_fire) begin
                st_reg <= st_new;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            stage_ch_reg <= s_tdata;
        end
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.out_byte;
    assign m_tuser  = {out_reg.quote_mode, out_reg.token_end, out_reg.token_kind,
                       out_reg.has_byte};
    assign m_tlast  = out_reg.last;

`ifndef SYNTH
    // a held second result always sits behind a valid first one
    a_hold_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> out_valid_reg)
        else $error("hold slot valid with empty result register");

    // only an operator token can be the second result of a byte
    a_hold_is_op: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> (hold_reg.token_kind && hold_reg.last && hold_reg.token_end))
        else $error("held result is not a closing operator");

    // a two-result byte fills both slots
    a_pair_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (stage_fire && res_cnt == 2'd2) |=> (out_valid_reg && hold_valid_reg))
        else $error("two-result byte did not fill both slots");

    // a result that is not the last of its byte has its partner waiting
    a_not_last_has_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> hold_valid_reg)
        else $error("non-final result without a pending partner");

    // escape is only armed in general mode
    a_esc_general: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.esc_pending |-> (st_reg.mode == sqt_pkg::MODE_GEN))
        else $error("escape pending inside quotes");
`endif

endmodule
